// ===== hdl/mres_pkg.sv =====
`default_nettype none

package mres_pkg;

    localparam int TIME_BITS_DEF      = 48;
    localparam int LINES_PER_FRAME_DEF = 525;
    localparam int QUEUE_DEPTH        = 2;

    localparam int NUM_CH      = 9;
    localparam int NUM_CFG     = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int PERIOD_W    = 32;
    localparam int FEAT_W      = 5;
    localparam int SCAN_W      = 10;
    localparam int STATUS_W    = 4;
    localparam int TICK_W      = 2;

    localparam logic [SCAN_W-1:0] RETRACE_FIRST_LINE = SCAN_W'(479);

    localparam logic [TICK_W-1:0] TICKS_NONE   = 2'd0;
    localparam logic [TICK_W-1:0] TICKS_NORMAL = 2'd1;
    localparam logic [TICK_W-1:0] TICKS_SLOW   = 2'd3;

    // Channel slots in the timestamp file.
    localparam int CH_SCAN  = 0;
    localparam int CH_IRQ   = 1;
    localparam int CH_MOUSE = 2;
    localparam int CH_SSRC  = 3;
    localparam int CH_CARD  = 4;
    localparam int CH_FM    = 5;
    localparam int CH_AUDIO = 6;
    localparam int CH_BLINK = 7;
    localparam int CH_DRAW  = 8;

    // Bits of the feature enable register.
    localparam int FEAT_AUDIO = 0;
    localparam int FEAT_SSRC  = 1;
    localparam int FEAT_CARD  = 2;
    localparam int FEAT_FM    = 3;
    localparam int FEAT_SLOW  = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCANLINE_PERIOD = 3'd0,
        REG_PIT_IRQ_PERIOD  = 3'd1,
        REG_MOUSE_PERIOD    = 3'd2,
        REG_SSOURCE_PERIOD  = 3'd3,
        REG_SAMPLE_PERIOD   = 3'd4,
        REG_CURSOR_PERIOD   = 3'd5,
        REG_DRAW_PERIOD     = 3'd6,
        REG_FEATURE_ENABLES = 3'd7
    } cfg_reg_t;

    localparam logic [PERIOD_W-1:0] RST_SCANLINE_PERIOD = 32'd31;
    localparam logic [PERIOD_W-1:0] RST_PIT_IRQ_PERIOD  = 32'd54925;
    localparam logic [PERIOD_W-1:0] RST_MOUSE_PERIOD    = 32'd86;
    localparam logic [PERIOD_W-1:0] RST_SSOURCE_PERIOD  = 32'd125;
    localparam logic [PERIOD_W-1:0] RST_SAMPLE_PERIOD   = 32'd20;
    localparam logic [PERIOD_W-1:0] RST_CURSOR_PERIOD   = 32'd266666;
    localparam logic [PERIOD_W-1:0] RST_DRAW_PERIOD     = 32'd20000;
    localparam logic [FEAT_W-1:0]   RST_FEATURE_ENABLES = 5'd0;

    typedef logic [PERIOD_W-1:0] period_t;

    // Which channels one poll is allowed to test, plus the slow tick flag, decided at the front.
    typedef struct packed {
        logic scan;
        logic irq;
        logic mouse;
        logic ssrc;
        logic card;
        logic fm;
        logic audio;
        logic blink;
        logic draw;
        logic slow;
    } chk_t;

    localparam int CHK_W = $bits(chk_t);

endpackage

`default_nettype wire

// ===== hdl/multi_rate_event_scheduler_top.sv =====
// Channel   Handshake             Payload
// poll in   in_valid / in_stall   now_time, pit0_active, card_period
// result    out_valid / out_stall fire_*, audio_ticks, scanline, retrace_status,
//                                 status_valid
// config    cfg_we                cfg_index, cfg_data (no read-back)
//
// One poll per cycle is sustained while out_stall does not hold the flow. A poll is
// captured in the input register at its transfer, is then written into a queue slot
// and from there moves into the output register, where its result is presented.
// The nine channel compares and timestamp updates run in parallel.
// Reset clears all timestamps, the scanline counter and the status nibble, and
// loads the period registers with their defaults. No clearing pass is needed.
// A two-entry queue separates front and back, so out_stall reaches in_stall only
// once the queue and input register are both full.
`default_nettype none

module multi_rate_event_scheduler_top #(
    parameter int TIME_BITS       = mres_pkg::TIME_BITS_DEF,
    parameter int LINES_PER_FRAME = mres_pkg::LINES_PER_FRAME_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [mres_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mres_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [TIME_BITS-1:0]            now_time,
    input  wire logic                            pit0_active,
    input  wire logic [mres_pkg::PERIOD_W-1:0]   card_period,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 fire_irq0,
    output logic                                 fire_mouse,
    output logic                                 fire_ssource,
    output logic                                 fire_card,
    output logic                                 fire_fm,
    output logic [mres_pkg::TICK_W-1:0]          audio_ticks,
    output logic                                 fire_blink,
    output logic                                 fire_draw,
    output logic [mres_pkg::SCAN_W-1:0]          scanline,
    output logic [mres_pkg::STATUS_W-1:0]        retrace_status,
    output logic                                 status_valid
);
    import mres_pkg::*;

    localparam int ITEM_W = TIME_BITS + PERIOD_W + CHK_W;

    period_t             period_reg [NUM_CFG-1];
    logic [FEAT_W-1:0]   feat_reg;

    logic                 push;
    logic                 q_full;
    logic                 q_not_empty;
    logic                 pop;
    logic [TIME_BITS-1:0] push_now;
    period_t              push_card;
    chk_t                 push_chk;
    logic [ITEM_W-1:0]    push_data;
    logic [ITEM_W-1:0]    pop_data;
    logic [TIME_BITS-1:0] q_now;
    period_t              q_card;
    chk_t                 q_chk;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg[REG_SCANLINE_PERIOD] <= RST_SCANLINE_PERIOD;
            period_reg[REG_PIT_IRQ_PERIOD]  <= RST_PIT_IRQ_PERIOD;
            period_reg[REG_MOUSE_PERIOD]    <= RST_MOUSE_PERIOD;
            period_reg[REG_SSOURCE_PERIOD]  <= RST_SSOURCE_PERIOD;
            period_reg[REG_SAMPLE_PERIOD]   <= RST_SAMPLE_PERIOD;
            period_reg[REG_CURSOR_PERIOD]   <= RST_CURSOR_PERIOD;
            period_reg[REG_DRAW_PERIOD]     <= RST_DRAW_PERIOD;
            feat_reg                        <= RST_FEATURE_ENABLES;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SCANLINE_PERIOD: period_reg[REG_SCANLINE_PERIOD] <= cfg_data;
                REG_PIT_IRQ_PERIOD:  period_reg[REG_PIT_IRQ_PERIOD]  <= cfg_data;
                REG_MOUSE_PERIOD:    period_reg[REG_MOUSE_PERIOD]    <= cfg_data;
                REG_SSOURCE_PERIOD:  period_reg[REG_SSOURCE_PERIOD]  <= cfg_data;
                REG_SAMPLE_PERIOD:   period_reg[REG_SAMPLE_PERIOD]   <= cfg_data;
                REG_CURSOR_PERIOD:   period_reg[REG_CURSOR_PERIOD]   <= cfg_data;
                REG_DRAW_PERIOD:     period_reg[REG_DRAW_PERIOD]     <= cfg_data;
                REG_FEATURE_ENABLES: feat_reg <= cfg_data[FEAT_W-1:0];
                default:             feat_reg <= feat_reg;
            endcase
        end
    end

    mres_front #(
        .TIME_BITS(TIME_BITS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .now_time        (now_time),
        .pit0_active     (pit0_active),
        .card_period     (card_period),
        .feature_enables (feat_reg),
        .push            (push),
        .q_full          (q_full),
        .push_now        (push_now),
        .push_card       (push_card),
        .push_chk        (push_chk)
    );

    assign push_data = {push_now, push_card, push_chk};

    mres_queue #(
        .WIDTH(ITEM_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .pop_data  (pop_data)
    );

    assign q_now  = pop_data[ITEM_W-1 -: TIME_BITS];
    assign q_card = pop_data[CHK_W +: PERIOD_W];
    assign q_chk  = chk_t'(pop_data[CHK_W-1:0]);

    mres_back #(
        .TIME_BITS       (TIME_BITS),
        .LINES_PER_FRAME (LINES_PER_FRAME)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_not_empty    (q_not_empty),
        .pop            (pop),
        .q_now          (q_now),
        .q_card         (q_card),
        .q_chk          (q_chk),
        .period_cfg     (period_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .fire_irq0      (fire_irq0),
        .fire_mouse     (fire_mouse),
        .fire_ssource   (fire_ssource),
        .fire_card      (fire_card),
        .fire_fm        (fire_fm),
        .audio_ticks    (audio_ticks),
        .fire_blink     (fire_blink),
        .fire_draw      (fire_draw),
        .scanline       (scanline),
        .retrace_status (retrace_status),
        .status_valid   (status_valid)
    );

endmodule

`default_nettype wire

// ===== hdl/mres_front.sv =====
`default_nettype none

module mres_front #(
    parameter int TIME_BITS = mres_pkg::TIME_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [TIME_BITS-1:0]          now_time,
    input  wire logic                          pit0_active,
    input  wire logic [mres_pkg::PERIOD_W-1:0] card_period,
    input  wire logic [mres_pkg::FEAT_W-1:0]   feature_enables,
    output logic                               push,
    input  wire logic                          q_full,
    output logic [TIME_BITS-1:0]               push_now,
    output mres_pkg::period_t                  push_card,
    output mres_pkg::chk_t                     push_chk
);
    import mres_pkg::*;

    logic                 valid_reg, valid_next;
    logic [TIME_BITS-1:0] now_reg;
    period_t              card_reg;
    chk_t                 chk_reg, chk_next;
    logic                 accept;
    logic                 audio_on;

    assign in_stall = valid_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign push     = valid_reg && !q_full;

    assign valid_next = accept || (valid_reg && !push);

    // Classify the poll: a channel that is gated off is neither tested nor moved.
    assign audio_on = feature_enables[FEAT_AUDIO];
    always_comb
    begin
        chk_next.scan  = 1'b1;
        chk_next.irq   = pit0_active;
        chk_next.mouse = 1'b1;
        chk_next.ssrc  = audio_on && feature_enables[FEAT_SSRC];
        chk_next.card  = audio_on && feature_enables[FEAT_CARD] && (card_period != '0);
        chk_next.fm    = audio_on && feature_enables[FEAT_FM];
        chk_next.audio = audio_on;
        chk_next.blink = 1'b1;
        chk_next.draw  = 1'b1;
        chk_next.slow  = feature_enables[FEAT_SLOW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg  <= now_time;
            card_reg <= card_period;
            chk_reg  <= chk_next;
        end
    end

    assign push_now  = now_reg;
    assign push_card = card_reg;
    assign push_chk  = chk_reg;

endmodule

`default_nettype wire

// ===== hdl/mres_queue.sv =====
`default_nettype none

module mres_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = mres_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output logic [WIDTH-1:0]      pop_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/mres_back.sv =====
`default_nettype none

module mres_back #(
    parameter int TIME_BITS       = mres_pkg::TIME_BITS_DEF,
    parameter int LINES_PER_FRAME = mres_pkg::LINES_PER_FRAME_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_not_empty,
    output logic                               pop,
    input  wire logic [TIME_BITS-1:0]          q_now,
    input  wire mres_pkg::period_t             q_card,
    input  wire mres_pkg::chk_t                q_chk,
    input  wire mres_pkg::period_t             period_cfg [mres_pkg::NUM_CFG-1],
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               fire_irq0,
    output logic                               fire_mouse,
    output logic                               fire_ssource,
    output logic                               fire_card,
    output logic                               fire_fm,
    output logic [mres_pkg::TICK_W-1:0]        audio_ticks,
    output logic                               fire_blink,
    output logic                               fire_draw,
    output logic [mres_pkg::SCAN_W-1:0]        scanline,
    output logic [mres_pkg::STATUS_W-1:0]      retrace_status,
    output logic                               status_valid
);
    import mres_pkg::*;

    localparam logic [SCAN_W-1:0] LAST_LINE = SCAN_W'(LINES_PER_FRAME - 1);

    logic [TIME_BITS-1:0] last_reg [NUM_CH];
    logic [TIME_BITS-1:0] last_next [NUM_CH];
    logic [TIME_BITS-1:0] period_ext [NUM_CH];
    logic [TIME_BITS-1:0] elapsed [NUM_CH];
    logic [NUM_CH-1:0]    chk_vec;
    logic [NUM_CH-1:0]    reload_vec;
    logic [NUM_CH-1:0]    hit;

    logic [SCAN_W-1:0]    line_reg, line_next;
    logic [STATUS_W-1:0]  status_reg, status_next;

    logic                 out_valid_reg, out_valid_next;
    logic [NUM_CH-1:0]    hit_reg;
    logic [TICK_W-1:0]    ticks_reg, ticks_next;

    // The output register frees up in the same cycle its result is taken.
    assign pop            = q_not_empty && (!out_valid_reg || !out_stall);
    assign out_valid_next = pop || (out_valid_reg && out_stall);

    always_comb
    begin
        chk_vec               = '0;
        chk_vec[CH_SCAN]      = q_chk.scan;
        chk_vec[CH_IRQ]       = q_chk.irq;
        chk_vec[CH_MOUSE]     = q_chk.mouse;
        chk_vec[CH_SSRC]      = q_chk.ssrc;
        chk_vec[CH_CARD]      = q_chk.card;
        chk_vec[CH_FM]        = q_chk.fm;
        chk_vec[CH_AUDIO]     = q_chk.audio;
        chk_vec[CH_BLINK]     = q_chk.blink;
        chk_vec[CH_DRAW]      = q_chk.draw;

        reload_vec            = '0;
        reload_vec[CH_IRQ]    = 1'b1;

        period_ext[CH_SCAN]   = TIME_BITS'(period_cfg[REG_SCANLINE_PERIOD]);
        period_ext[CH_IRQ]    = TIME_BITS'(period_cfg[REG_PIT_IRQ_PERIOD]);
        period_ext[CH_MOUSE]  = TIME_BITS'(period_cfg[REG_MOUSE_PERIOD]);
        period_ext[CH_SSRC]   = TIME_BITS'(period_cfg[REG_SSOURCE_PERIOD]);
        period_ext[CH_CARD]   = TIME_BITS'(q_card);
        period_ext[CH_FM]     = TIME_BITS'(period_cfg[REG_SAMPLE_PERIOD]);
        period_ext[CH_AUDIO]  = TIME_BITS'(period_cfg[REG_SAMPLE_PERIOD]);
        period_ext[CH_BLINK]  = TIME_BITS'(period_cfg[REG_CURSOR_PERIOD]);
        period_ext[CH_DRAW]   = TIME_BITS'(period_cfg[REG_DRAW_PERIOD]);
    end

    // Each channel is an independent subtract, compare and update.
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            elapsed[c]   = q_now - last_reg[c];
            hit[c]       = pop && chk_vec[c] && (elapsed[c] >= period_ext[c]);
            last_next[c] = last_reg[c];
            if (hit[c])
            begin
                last_next[c] = reload_vec[c] ? q_now : last_reg[c] + period_ext[c];
            end
        end
    end

    always_comb
    begin
        line_next   = line_reg;
        status_next = status_reg;
        if (hit[CH_SCAN])
        begin
            line_next   = (line_reg == LAST_LINE) ? '0 : line_reg + 1'b1;
            status_next = {(line_next > RETRACE_FIRST_LINE), 2'b00, line_next[0]};
        end
        if (hit[CH_AUDIO])
        begin
            ticks_next = q_chk.slow ? TICKS_SLOW : TICKS_NORMAL;
        end
        else
        begin
            ticks_next = TICKS_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                last_reg[c] <= '0;
            end
            line_reg      <= '0;
            status_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                last_reg[c] <= last_next[c];
            end
            line_reg      <= line_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            hit_reg   <= hit;
            ticks_reg <= ticks_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign fire_irq0      = hit_reg[CH_IRQ];
    assign fire_mouse     = hit_reg[CH_MOUSE];
    assign fire_ssource   = hit_reg[CH_SSRC];
    assign fire_card      = hit_reg[CH_CARD];
    assign fire_fm        = hit_reg[CH_FM];
    assign audio_ticks    = ticks_reg;
    assign fire_blink     = hit_reg[CH_BLINK];
    assign fire_draw      = hit_reg[CH_DRAW];
    assign status_valid   = hit_reg[CH_SCAN];
    // Scanline and status registers only move on a pop, so they match the held result.
    assign scanline       = line_reg;
    assign retrace_status = status_reg;

    a_line_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg <= LAST_LINE)
        else $error("scanline counter left the frame");

    a_status_odd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_valid |-> retrace_status[0] == scanline[0])
        else $error("retrace odd bit does not follow scanline");

    a_ticks_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> audio_ticks != 2'd2)
        else $error("audio tick count has an impossible value");

    a_irq_reload: assert property (@(posedge clk) disable iff (!rst_n)
        hit[CH_IRQ] |=> last_reg[CH_IRQ] == $past(q_now))
        else $error("timer interrupt channel did not reload to the poll time");

    a_pop_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !pop)
        else $error("result overwritten while the output was stalled");

endmodule

`default_nettype wire
